// ----- hw/rtl/cell_surface_length_change_macros.svh -----
// Assertion macros for the cell surface length change block.
// Taken in by the top level; no other dependencies.
`ifndef CELL_SURFACE_LENGTH_CHANGE_MACROS_SVH
`define CELL_SURFACE_LENGTH_CHANGE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CSLC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cslc assertion failed");
`define CSLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cslc assertion failed");
`else
`define CSLC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CSLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/cslc_pkg.sv -----
// Shared types and constants for the cell surface length change block.
// No dependencies.
`default_nettype none
package cslc_pkg;
   localparam int UNIT_W    = 8;
   localparam int HGT_W     = 8;
   localparam int OUT_W     = 31;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_HORIZONTAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_VERTICAL   = 1'b1;

   localparam logic [UNIT_W-1:0] HORIZONTAL_RESET = 8'd30;
   localparam logic [UNIT_W-1:0] VERTICAL_RESET   = 8'd11;

   localparam longint OUT_MAX = 64'sd1073741823;
   localparam longint OUT_MIN = -64'sd1073741824;

   typedef struct packed {
      logic [HGT_W-1:0] x0y0;
      logic [HGT_W-1:0] x1y0;
      logic [HGT_W-1:0] x1y1;
      logic [HGT_W-1:0] x0y1;
   } corners_type;

   typedef struct packed {
      logic valid;
      logic cut;
   } tag_type;
endpackage
`default_nettype wire

// ----- hw/rtl/cell_surface_length_change.sv -----
// Block usage
// req channel: one path segment per transaction, two points on one grid cell's
//   boundary plus the before and after corner heights. rsp channel: one
//   transaction per segment with the after minus before surface length
//   (signed, FRAC_BITS fraction bits, saturated) and a flag in rsp_tuser set
//   when the segment was split at the cell's anti-diagonal.
// csr channel: index 0 horizontal unit, index 1 vertical unit; always ready.
//   Write only while no segment is in flight.
// Pipeline: one offset stage, the cut test, a divider giving one quotient
//   bit per stage, the cut-point stage, five lane stages, a square root with
//   an input stage and one root bit per stage, the piece sum and the output
//   queue.
// Throughput: one segment per cycle while the output queue is not full;
//   two lanes (before, after) run side by side and a merge stage subtracts
//   them into a two-entry output queue.
// Stall: when rsp_tready is low the queue absorbs one more result, then the
//   whole pipeline holds and req_tready drops until an entry is taken.
// Reset: empties the pipeline and queue, units return to 30 and 11.
`default_nettype none
`include "cell_surface_length_change_macros.svh"
module cell_surface_length_change #(
   parameter int COORD_INT_BITS = 12,
   parameter int FRAC_BITS      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x, start_y, end_x, end_y, before_x0y0, before_x1y0, before_x1y1,
   // before_x0y1, after_x0y0, after_x1y0, after_x1y1, after_x0y1, zero pad
   input  logic [((4*(COORD_INT_BITS+FRAC_BITS)+64+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // surface_change, one zero pad bit
   output logic [31:0]                       rsp_tdata,
   // diagonal_cut
   output logic                              rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cslc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cslc_pkg::UNIT_W-1:0]       csr_data
);
   localparam int CW     = COORD_INT_BITS + FRAC_BITS;
   localparam int P_W    = FRAC_BITS + 1;
   localparam int HG     = cslc_pkg::HGT_W;
   localparam int LEN_W  = FRAC_BITS + 18;
   localparam int SIDE_W = 4 * P_W + 8 * HG;
   localparam int OUT_W  = cslc_pkg::OUT_W;
   localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

   // configuration
   logic [cslc_pkg::UNIT_W-1:0] h_unit_ff, v_unit_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         h_unit_ff <= cslc_pkg::HORIZONTAL_RESET;
         v_unit_ff <= cslc_pkg::VERTICAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            cslc_pkg::REG_HORIZONTAL: h_unit_ff <= csr_data;
            cslc_pkg::REG_VERTICAL:   v_unit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // output queue occupancy decides whether the pipeline moves
   logic [1:0] cnt_ff, cnt_in;
   logic       en, push, pop;
   assign en = (cnt_ff != 2'd2);
   assign req_tready = en;

   // offsets from the cell origin, saturated to one step
   function automatic logic [P_W-1:0] offset(input logic [CW-1:0] raw,
                                             input logic [CW-1:0] base);
      logic [CW-1:0] off;
      off = raw - base;
      return (off > ONE) ? P_W'(ONE) : off[P_W-1:0];
   endfunction

   logic [CW-1:0] sx, sy, ex, ey, min_x, min_y, base_x, base_y;
   assign sx = req_tdata[0*CW +: CW];
   assign sy = req_tdata[1*CW +: CW];
   assign ex = req_tdata[2*CW +: CW];
   assign ey = req_tdata[3*CW +: CW];
   assign min_x  = (sx < ex) ? sx : ex;
   assign min_y  = (sy < ey) ? sy : ey;
   assign base_x = {min_x[CW-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
   assign base_y = {min_y[CW-1:FRAC_BITS], {FRAC_BITS{1'b0}}};

   logic                  s1_valid_ff;
   logic [P_W-1:0]        p0_ff, p1_ff, p2_ff, p3_ff;
   cslc_pkg::corners_type before_ff, after_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
      if (en) begin
         p0_ff <= offset(sx, base_x);
         p1_ff <= offset(sy, base_y);
         p2_ff <= offset(ex, base_x);
         p3_ff <= offset(ey, base_y);
         before_ff <= req_tdata[4*CW +: 4*HG];
         after_ff  <= req_tdata[4*CW+4*HG +: 4*HG];
      end
   end

   // reorder tdata corner bytes (x0y0 lowest) into the struct order
   cslc_pkg::corners_type before_c, after_c;
   assign before_c = '{x0y0: before_ff[4*HG-1 -: HG], x1y0: before_ff[3*HG-1 -: HG],
                       x1y1: before_ff[2*HG-1 -: HG], x0y1: before_ff[HG-1 -: HG]};
   assign after_c  = '{x0y0: after_ff[4*HG-1 -: HG], x1y0: after_ff[3*HG-1 -: HG],
                       x1y1: after_ff[2*HG-1 -: HG], x0y1: after_ff[HG-1 -: HG]};
   // packed struct puts x0y0 highest; swap so each field gets its own byte
   cslc_pkg::corners_type before_k, after_k;
   assign before_k = '{x0y0: before_c.x0y1, x1y0: before_c.x1y1,
                       x1y1: before_c.x1y0, x0y1: before_c.x0y0};
   assign after_k  = '{x0y0: after_c.x0y1, x1y0: after_c.x1y1,
                       x1y1: after_c.x1y0, x0y1: after_c.x0y0};

   logic                  c_valid, c_cut;
   logic [P_W-1:0]        c_mx, c_my;
   logic [SIDE_W-1:0]     c_side;
   logic [P_W-1:0]        q0, q1, q2, q3;
   cslc_pkg::corners_type q_before, q_after;

   cslc_cut #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SIDE_W)
   ) u_cut (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_p0     (p0_ff),
      .in_p1     (p1_ff),
      .in_p2     (p2_ff),
      .in_p3     (p3_ff),
      .in_side   ({p0_ff, p1_ff, p2_ff, p3_ff, before_k, after_k}),
      .out_valid (c_valid),
      .out_cut   (c_cut),
      .out_mx    (c_mx),
      .out_my    (c_my),
      .out_side  (c_side)
   );

   assign {q0, q1, q2, q3, q_before, q_after} = c_side;

   logic             lb_valid, la_valid, lb_cut, la_cut;
   logic [LEN_W-1:0] len_before, len_after;

   cslc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_before (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (c_valid),
      .in_cut     (c_cut),
      .in_p0      (q0),
      .in_p1      (q1),
      .in_p2      (q2),
      .in_p3      (q3),
      .in_mx      (c_mx),
      .in_my      (c_my),
      .in_corners (q_before),
      .h_unit     (h_unit_ff),
      .v_unit     (v_unit_ff),
      .out_valid  (lb_valid),
      .out_cut    (lb_cut),
      .out_length (len_before)
   );

   cslc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_after (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (c_valid),
      .in_cut     (c_cut),
      .in_p0      (q0),
      .in_p1      (q1),
      .in_p2      (q2),
      .in_p3      (q3),
      .in_mx      (c_mx),
      .in_my      (c_my),
      .in_corners (q_after),
      .h_unit     (h_unit_ff),
      .v_unit     (v_unit_ff),
      .out_valid  (la_valid),
      .out_cut    (la_cut),
      .out_length (len_after)
   );

   // merge: after minus before, saturated
   logic signed [LEN_W:0] diff;
   longint                diff_l;
   logic [OUT_W-1:0]      sat;
   assign diff   = signed'({1'b0, len_after}) - signed'({1'b0, len_before});
   assign diff_l = longint'(diff);
   always_comb begin
      if (diff_l > cslc_pkg::OUT_MAX) begin
         sat = OUT_W'(cslc_pkg::OUT_MAX);
      end else if (diff_l < cslc_pkg::OUT_MIN) begin
         sat = OUT_W'(cslc_pkg::OUT_MIN);
      end else begin
         sat = diff_l[OUT_W-1:0];
      end
   end

   // two-entry output queue
   logic [OUT_W-1:0] head_ff, tail_ff;
   logic             head_cut_ff, tail_cut_ff;

   assign push = en && lb_valid && la_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (pop) begin
         if (push && cnt_ff == 2'd1) begin
            head_ff     <= sat;
            head_cut_ff <= lb_cut;
         end else begin
            head_ff     <= tail_ff;
            head_cut_ff <= tail_cut_ff;
            if (push) begin
               tail_ff     <= sat;
               tail_cut_ff <= lb_cut;
            end
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            head_ff     <= sat;
            head_cut_ff <= lb_cut;
         end else begin
            tail_ff     <= sat;
            tail_cut_ff <= lb_cut;
         end
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {1'b0, head_ff};
   assign rsp_tuser  = head_cut_ff;

   `CSLC_ASSERT_IMPLY(a_full_blocks_req, clock, reset, cnt_ff == 2'd2, !req_tready)
   `CSLC_ASSERT_NEXT(a_drain_keeps_valid, clock, reset, pop && !push && cnt_ff == 2'd2, rsp_tvalid)
   `CSLC_ASSERT_IMPLY(a_lanes_aligned, clock, reset, 1'b1, lb_valid == la_valid)
   `CSLC_ASSERT_IMPLY(a_lanes_cut_agree, clock, reset, lb_valid, lb_cut == la_cut)
endmodule
`default_nettype wire

// ----- hw/rtl/cslc_cut.sv -----
// Diagonal cut test and pipelined restoring divider for the cut point.
// Depends on nothing but its parameters.
`default_nettype none
module cslc_cut #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [FRAC_BITS:0]   in_p0,
   input  logic [FRAC_BITS:0]   in_p1,
   input  logic [FRAC_BITS:0]   in_p2,
   input  logic [FRAC_BITS:0]   in_p3,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic                 out_cut,
   output logic [FRAC_BITS:0]   out_mx,
   output logic [FRAC_BITS:0]   out_my,
   output logic [SIDE_W-1:0]    out_side
);
   localparam int P_W   = FRAC_BITS + 1;
   localparam int S_W   = FRAC_BITS + 2;
   localparam int D_W   = FRAC_BITS + 3;
   localparam int M_W   = 2 * FRAC_BITS + 5;
   localparam int REM_W = 2 * FRAC_BITS + 4;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int X_W   = FRAC_BITS + 4;
   localparam int NSTG  = Q_W;
   localparam logic [S_W-1:0] ONE = S_W'(1) << FRAC_BITS;

   logic [S_W-1:0]          sa, sb;
   logic                    corner_a, corner_b, in_range, cut_c, neg_c;
   logic signed [D_W-1:0]   den, dp, ev;
   logic signed [M_W-1:0]   num;
   logic [M_W-1:0]          num_mag;
   logic [D_W-1:0]          den_mag;

   assign sa = S_W'(in_p0) + S_W'(in_p1);
   assign sb = S_W'(in_p2) + S_W'(in_p3);
   assign corner_a = (S_W'(in_p0) == ONE && in_p1 == '0) || (in_p0 == '0 && S_W'(in_p1) == ONE);
   assign corner_b = (S_W'(in_p2) == ONE && in_p3 == '0) || (in_p2 == '0 && S_W'(in_p3) == ONE);
   assign in_range = (sa <= ONE && ONE <= sb) || (sb <= ONE && ONE <= sa);
   assign cut_c = !corner_a && !corner_b && (sa != sb) && in_range;
   assign den = signed'(D_W'(sb)) - signed'(D_W'(sa));
   assign dp  = signed'(D_W'(in_p2)) - signed'(D_W'(in_p0));
   assign ev  = signed'(D_W'(ONE)) - signed'(D_W'(sa));
   assign num = M_W'(dp) * M_W'(ev);
   assign neg_c = num[M_W-1] ^ den[D_W-1];
   assign num_mag = num[M_W-1] ? M_W'(-num) : M_W'(num);
   assign den_mag = den[D_W-1] ? D_W'(-den) : D_W'(den);

   logic              valid_ff [0:NSTG];
   logic              cut_ff   [0:NSTG];
   logic              neg_ff   [0:NSTG];
   logic [REM_W-1:0]  rem_ff   [0:NSTG];
   logic [Q_W-1:0]    quo_ff   [0:NSTG];
   logic [D_W-1:0]    d_ff     [0:NSTG];
   logic [P_W-1:0]    p0_ff    [0:NSTG];
   logic [SIDE_W-1:0] side_ff  [0:NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
      if (en) begin
         cut_ff[0]  <= cut_c;
         neg_ff[0]  <= neg_c;
         rem_ff[0]  <= {num_mag[REM_W-2:0], 1'b0} + REM_W'(den_mag);
         quo_ff[0]  <= '0;
         d_ff[0]    <= {den_mag[D_W-2:0], 1'b0};
         p0_ff[0]   <= in_p0;
         side_ff[0] <= in_side;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < NSTG; j++) begin : g_div
      localparam int K = NSTG - 1 - j;
      logic [REM_W-1:0] sub;
      logic             ge;
      assign sub = REM_W'(d_ff[j]) << K;
      assign ge  = rem_ff[j] >= sub;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            valid_ff[j+1] <= valid_ff[j];
         end
         if (en) begin
            cut_ff[j+1]  <= cut_ff[j];
            neg_ff[j+1]  <= neg_ff[j];
            rem_ff[j+1]  <= ge ? rem_ff[j] - sub : rem_ff[j];
            quo_ff[j+1]  <= {quo_ff[j][Q_W-2:0], ge};
            d_ff[j+1]    <= d_ff[j];
            p0_ff[j+1]   <= p0_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   logic signed [X_W-1:0] mx_s;
   logic [P_W-1:0]        mx_c;
   assign mx_s = neg_ff[NSTG] ? signed'(X_W'(p0_ff[NSTG])) - signed'(X_W'(quo_ff[NSTG]))
                              : signed'(X_W'(p0_ff[NSTG])) + signed'(X_W'(quo_ff[NSTG]));
   always_comb begin
      if (mx_s < 0) begin
         mx_c = '0;
      end else if (mx_s > signed'(X_W'(ONE))) begin
         mx_c = P_W'(ONE);
      end else begin
         mx_c = mx_s[P_W-1:0];
      end
   end

   logic              out_valid_ff, out_cut_ff;
   logic [P_W-1:0]    out_mx_ff, out_my_ff;
   logic [SIDE_W-1:0] out_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= valid_ff[NSTG];
      end
      if (en) begin
         out_cut_ff  <= cut_ff[NSTG];
         out_mx_ff   <= mx_c;
         out_my_ff   <= P_W'(ONE) - mx_c;
         out_side_ff <= side_ff[NSTG];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cut   = out_cut_ff;
   assign out_mx    = out_mx_ff;
   assign out_my    = out_my_ff;
   assign out_side  = out_side_ff;
endmodule
`default_nettype wire

// ----- hw/rtl/cslc_sqrt2.sv -----
// Two pipelined digit-by-digit integer square roots, one root bit per stage.
// Uses cslc_pkg for the tag carried beside the data.
`default_nettype none
module cslc_sqrt2 #(
   parameter int RAD_W  = 66,
   parameter int ROOT_W = 33
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cslc_pkg::tag_type   in_tag,
   input  logic [RAD_W-1:0]    rad_a,
   input  logic [RAD_W-1:0]    rad_b,
   output cslc_pkg::tag_type   out_tag,
   output logic [ROOT_W-1:0]   root_a,
   output logic [ROOT_W-1:0]   root_b
);
   localparam int T_W = RAD_W + 2;

   cslc_pkg::tag_type tag_ff   [0:ROOT_W];
   logic [RAD_W-1:0]  rem_a_ff [0:ROOT_W];
   logic [RAD_W-1:0]  rem_b_ff [0:ROOT_W];
   logic [ROOT_W-1:0] rt_a_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] rt_b_ff  [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0].valid <= 1'b0;
      end else if (en) begin
         tag_ff[0].valid <= in_tag.valid;
      end
      if (en) begin
         tag_ff[0].cut <= in_tag.cut;
         rem_a_ff[0]   <= rad_a;
         rem_b_ff[0]   <= rad_b;
         rt_a_ff[0]    <= '0;
         rt_b_ff[0]    <= '0;
      end
   end

   for (genvar j = 0; j < ROOT_W; j++) begin : g_root
      localparam int I = ROOT_W - 1 - j;
      logic [T_W-1:0] trial_a, trial_b;
      logic           take_a, take_b;
      assign trial_a = (T_W'(rt_a_ff[j]) << (I + 1)) | (T_W'(1) << (2 * I));
      assign trial_b = (T_W'(rt_b_ff[j]) << (I + 1)) | (T_W'(1) << (2 * I));
      assign take_a  = trial_a <= T_W'(rem_a_ff[j]);
      assign take_b  = trial_b <= T_W'(rem_b_ff[j]);
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j+1].valid <= 1'b0;
         end else if (en) begin
            tag_ff[j+1].valid <= tag_ff[j].valid;
         end
         if (en) begin
            tag_ff[j+1].cut <= tag_ff[j].cut;
            rem_a_ff[j+1] <= take_a ? rem_a_ff[j] - trial_a[RAD_W-1:0] : rem_a_ff[j];
            rem_b_ff[j+1] <= take_b ? rem_b_ff[j] - trial_b[RAD_W-1:0] : rem_b_ff[j];
            rt_a_ff[j+1]  <= take_a ? rt_a_ff[j] | (ROOT_W'(1) << I) : rt_a_ff[j];
            rt_b_ff[j+1]  <= take_b ? rt_b_ff[j] | (ROOT_W'(1) << I) : rt_b_ff[j];
         end
      end
   end

   assign out_tag = tag_ff[ROOT_W];
   assign root_a  = rt_a_ff[ROOT_W];
   assign root_b  = rt_b_ff[ROOT_W];
endmodule
`default_nettype wire

// ----- hw/rtl/cslc_lane.sv -----
// One surface lane: point heights, piece deltas, squared lengths, roots, sum.
// Depends on cslc_pkg and cslc_sqrt2.
`default_nettype none
module cslc_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic                          in_cut,
   input  logic [FRAC_BITS:0]            in_p0,
   input  logic [FRAC_BITS:0]            in_p1,
   input  logic [FRAC_BITS:0]            in_p2,
   input  logic [FRAC_BITS:0]            in_p3,
   input  logic [FRAC_BITS:0]            in_mx,
   input  logic [FRAC_BITS:0]            in_my,
   input  cslc_pkg::corners_type         in_corners,
   input  logic [cslc_pkg::UNIT_W-1:0]   h_unit,
   input  logic [cslc_pkg::UNIT_W-1:0]   v_unit,
   output logic                          out_valid,
   output logic                          out_cut,
   output logic [FRAC_BITS+17:0]         out_length
);
   localparam int P_W    = FRAC_BITS + 1;
   localparam int HG     = cslc_pkg::HGT_W;
   localparam int HX_W   = P_W + cslc_pkg::UNIT_W;
   localparam int Z_W    = HG + cslc_pkg::UNIT_W;
   localparam int RAD_W  = 2 * FRAC_BITS + 34;
   localparam int ROOT_W = FRAC_BITS + 17;
   localparam int LEN_W  = FRAC_BITS + 18;
   localparam logic [P_W-1:0] ONE = P_W'(1) << FRAC_BITS;

   function automatic logic [HG-1:0] lerp(input logic [HG-1:0] v1, input logic [HG-1:0] v2,
                                          input logic [P_W-1:0] t);
      logic signed [HG:0]         d;
      logic signed [P_W+HG+1:0]   prod;
      logic signed [P_W+HG+1:0]   sh;
      d    = signed'({1'b0, v2}) - signed'({1'b0, v1});
      prod = (P_W+HG+2)'(d) * (P_W+HG+2)'(signed'({1'b0, t}));
      sh   = prod >>> FRAC_BITS;
      return v1 + sh[HG-1:0];
   endfunction

   function automatic logic [HG-1:0] point_height(input logic [P_W-1:0] lx,
                                                  input logic [P_W-1:0] ly,
                                                  input cslc_pkg::corners_type c);
      logic [HG-1:0] h;
      if (lx == '0) begin
         h = lerp(c.x0y0, c.x0y1, ly);
      end else if (lx == ONE) begin
         h = lerp(c.x1y0, c.x1y1, ly);
      end else if (ly == '0) begin
         h = lerp(c.x0y0, c.x1y0, lx);
      end else if (ly == ONE) begin
         h = lerp(c.x1y1, c.x0y1, ONE - lx);
      end else begin
         h = lerp(c.x1y0, c.x0y1, ONE - lx);
      end
      return h;
   endfunction

   function automatic logic [P_W-1:0] absdiff(input logic [P_W-1:0] a, input logic [P_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // stage 1: heights at both ends and at the cut point
   cslc_pkg::tag_type t1_ff;
   logic [P_W-1:0]    ax_ff, ay_ff, bx_ff, by_ff, mx_ff, my_ff;
   logic [HG-1:0]     ha_ff, hb_ff, hm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
      end else if (en) begin
         t1_ff.valid <= in_valid;
      end
      if (en) begin
         t1_ff.cut <= in_cut;
         ax_ff <= in_p0;
         ay_ff <= in_p1;
         bx_ff <= in_p2;
         by_ff <= in_p3;
         mx_ff <= in_mx;
         my_ff <= in_my;
         ha_ff <= point_height(in_p0, in_p1, in_corners);
         hb_ff <= point_height(in_p2, in_p3, in_corners);
         hm_ff <= point_height(in_mx, in_my, in_corners);
      end
   end

   // stage 2: deltas; first piece ends at the cut point or at the far end
   cslc_pkg::tag_type t2_ff;
   logic [P_W-1:0]    dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic [HG-1:0]     dz1_ff, dz2_ff;
   logic [P_W-1:0]    ex, ey;
   logic [HG-1:0]     eh;

   assign ex = t1_ff.cut ? mx_ff : bx_ff;
   assign ey = t1_ff.cut ? my_ff : by_ff;
   assign eh = t1_ff.cut ? hm_ff : hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_ff.valid <= 1'b0;
      end else if (en) begin
         t2_ff.valid <= t1_ff.valid;
      end
      if (en) begin
         t2_ff.cut <= t1_ff.cut;
         dx1_ff <= absdiff(ax_ff, ex);
         dy1_ff <= absdiff(ay_ff, ey);
         dz1_ff <= (ha_ff > eh) ? ha_ff - eh : eh - ha_ff;
         dx2_ff <= t1_ff.cut ? absdiff(bx_ff, mx_ff) : '0;
         dy2_ff <= t1_ff.cut ? absdiff(by_ff, my_ff) : '0;
         dz2_ff <= !t1_ff.cut ? '0 : (hb_ff > hm_ff) ? hb_ff - hm_ff : hm_ff - hb_ff;
      end
   end

   // stage 3: scale by the units
   cslc_pkg::tag_type t3_ff;
   logic [HX_W-1:0]   hx1_ff, hy1_ff, hx2_ff, hy2_ff;
   logic [Z_W-1:0]    hz1_ff, hz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_ff.valid <= 1'b0;
      end else if (en) begin
         t3_ff.valid <= t2_ff.valid;
      end
      if (en) begin
         t3_ff.cut <= t2_ff.cut;
         hx1_ff <= HX_W'(dx1_ff) * HX_W'(h_unit);
         hy1_ff <= HX_W'(dy1_ff) * HX_W'(h_unit);
         hx2_ff <= HX_W'(dx2_ff) * HX_W'(h_unit);
         hy2_ff <= HX_W'(dy2_ff) * HX_W'(h_unit);
         hz1_ff <= Z_W'(dz1_ff) * Z_W'(v_unit);
         hz2_ff <= Z_W'(dz2_ff) * Z_W'(v_unit);
      end
   end

   // stage 4: squares
   cslc_pkg::tag_type t4_ff;
   logic [2*HX_W-1:0] sx1_ff, sy1_ff, sx2_ff, sy2_ff;
   logic [2*Z_W-1:0]  sz1_ff, sz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_ff.valid <= 1'b0;
      end else if (en) begin
         t4_ff.valid <= t3_ff.valid;
      end
      if (en) begin
         t4_ff.cut <= t3_ff.cut;
         sx1_ff <= (2*HX_W)'(hx1_ff) * (2*HX_W)'(hx1_ff);
         sy1_ff <= (2*HX_W)'(hy1_ff) * (2*HX_W)'(hy1_ff);
         sx2_ff <= (2*HX_W)'(hx2_ff) * (2*HX_W)'(hx2_ff);
         sy2_ff <= (2*HX_W)'(hy2_ff) * (2*HX_W)'(hy2_ff);
         sz1_ff <= (2*Z_W)'(hz1_ff) * (2*Z_W)'(hz1_ff);
         sz2_ff <= (2*Z_W)'(hz2_ff) * (2*Z_W)'(hz2_ff);
      end
   end

   // stage 5: sum of squares; vertical term carries the fraction shift twice
   cslc_pkg::tag_type t5_ff;
   logic [RAD_W-1:0]  rad1_ff, rad2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t5_ff.valid <= 1'b0;
      end else if (en) begin
         t5_ff.valid <= t4_ff.valid;
      end
      if (en) begin
         t5_ff.cut <= t4_ff.cut;
         rad1_ff <= RAD_W'(sx1_ff) + RAD_W'(sy1_ff) + (RAD_W'(sz1_ff) << (2 * FRAC_BITS));
         rad2_ff <= RAD_W'(sx2_ff) + RAD_W'(sy2_ff) + (RAD_W'(sz2_ff) << (2 * FRAC_BITS));
      end
   end

   cslc_pkg::tag_type root_tag;
   logic [ROOT_W-1:0] root1, root2;

   cslc_sqrt2 #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_tag  (t5_ff),
      .rad_a   (rad1_ff),
      .rad_b   (rad2_ff),
      .out_tag (root_tag),
      .root_a  (root1),
      .root_b  (root2)
   );

   logic             valid_ff, cut_ff;
   logic [LEN_W-1:0] length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= root_tag.valid;
      end
      if (en) begin
         cut_ff    <= root_tag.cut;
         length_ff <= LEN_W'(root1) + LEN_W'(root2);
      end
   end

   assign out_valid  = valid_ff;
   assign out_cut    = cut_ff;
   assign out_length = length_ff;
endmodule
`default_nettype wire
